// ===== sv/tcc_pkg.sv =====
`timescale 1ns / 1ps

package tcc_pkg;

    localparam int DEF_MAX_COLS = 128;
    localparam int DEF_MAX_ROWS = 32;

    localparam int CUR_W      = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd1;

    localparam logic [7:0] COLS_RESET = 8'd80;
    localparam logic [5:0] ROWS_RESET = 6'd25;

    localparam logic [1:0] FN_PUT   = 2'd0;
    localparam logic [1:0] FN_SET   = 2'd1;
    localparam logic [1:0] FN_CLEAR = 2'd2;
    localparam logic [1:0] FN_READ  = 2'd3;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_RETURN  = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] char_code;
        logic [6:0] col;
        logic [4:0] row;
    } t_in_item;

    typedef struct packed {
        logic [CUR_W-1:0] cursor_now;
        logic [7:0]       cell_value;
    } t_out_item;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_store_ctl;

endpackage

// ===== sv/tcc_div.sv =====
`timescale 1ns / 1ps

module tcc_div #(
    parameter int WW = 13,
    parameter int CW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [WW-1:0] i_dividend,
    input  logic [CW-1:0] i_divisor,
    output logic          o_done,
    output logic [CW-1:0] o_rem
);
    localparam int NW = $clog2(WW + 1);

    logic          r_busy;
    logic          r_done;
    logic [NW-1:0] r_cnt;
    logic [CW-1:0] r_rem;
    logic [WW-1:0] r_dvd;
    logic [CW:0]   partial;
    logic [CW-1:0] rem_step;

    // restoring division, one quotient bit a cycle
    always_comb begin
        partial = {r_rem, r_dvd[WW-1]};
        if (partial >= {1'b0, i_divisor}) begin
            rem_step = CW'(partial - {1'b0, i_divisor});
        end else begin
            rem_step = CW'(partial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == NW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= NW'(WW);
            r_rem <= '0;
            r_dvd <= i_dividend;
        end else if (r_busy) begin
            r_cnt <= r_cnt - NW'(1);
            r_rem <= rem_step;
            r_dvd <= {r_dvd[WW-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== sv/tcc_store.sv =====
`timescale 1ns / 1ps

module tcc_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic               i_clk,
    input  tcc_pkg::t_store_ctl i_ctl,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [7:0]         i_wr_data,
    input  logic [AW-1:0]      i_rd_addr,
    output logic [7:0]         o_rd_data
);
    import tcc_pkg::*;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/text_console_cursor_scroll_top.sv =====
`timescale 1ns / 1ps
// A newline or carriage return waits on the remainder divider for the column;
// a put that runs past the last screen cell scrolls the screen up one row, and
// clear screen writes a space to every screen cell. Throughput: one beat at a time.
// Reset (synchronous, active low) starts a clearing pass over all MAX_COLS*MAX_ROWS
// cells, one cell a cycle, during which no input beat is taken.

module text_console_cursor_scroll_top #(
    parameter int MAX_COLS = tcc_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = tcc_pkg::DEF_MAX_ROWS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  tcc_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output tcc_pkg::t_out_item                o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tcc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tcc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import tcc_pkg::*;

    localparam int CW          = $clog2(MAX_COLS + 1);
    localparam int RW          = $clog2(MAX_ROWS + 1);
    localparam int PW          = CW + RW;
    localparam int STORE_CELLS = MAX_COLS * MAX_ROWS;
    localparam int AW          = (STORE_CELLS > 1) ? $clog2(STORE_CELLS) : 1;
    localparam int TW          = $clog2(STORE_CELLS + 1);
    localparam int WW          = (TW + 1 > CUR_W) ? TW + 1 : CUR_W;

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_PREP   = 4'd2;
    localparam logic [3:0] S_DISP   = 4'd3;
    localparam logic [3:0] S_RDWAIT = 4'd4;
    localparam logic [3:0] S_DIV    = 4'd5;
    localparam logic [3:0] S_CHECK  = 4'd6;
    localparam logic [3:0] S_SCROLL = 4'd7;
    localparam logic [3:0] S_FILL   = 4'd8;
    localparam logic [3:0] S_CLEAR  = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    // control state
    logic [3:0]       r_state,       n_state;
    logic [7:0]       r_cols_in_use, n_cols_in_use;
    logic [5:0]       r_rows_in_use, n_rows_in_use;
    logic [CUR_W-1:0] r_cursor,      n_cursor;
    logic [TW-1:0]    r_dst,         n_dst;
    logic             r_mv,          n_mv;
    logic             r_out_valid,   n_out_valid;

    // working registers
    logic [1:0]       r_func,  n_func;
    logic [7:0]       r_char,  n_char;
    logic [CW-1:0]    r_cols,  n_cols;
    logic [RW-1:0]    r_rows,  n_rows;
    logic [CW-1:0]    r_c,     n_c;
    logic [RW-1:0]    r_r,     n_r;
    logic [TW-1:0]    r_total, n_total;
    logic [TW-1:0]    r_lin,   n_lin;
    logic [WW-1:0]    r_cur,   n_cur;
    logic [TW-1:0]    r_src,   n_src;
    logic [7:0]       r_cell,  n_cell;
    t_out_item        r_out,   n_out;

    logic [CW-1:0]    cols_eff;
    logic [RW-1:0]    rows_eff;
    logic [WW-1:0]    cur_clamp;
    logic [WW-1:0]    line_start;
    logic             div_start;
    logic             div_done;
    logic [CW-1:0]    div_rem;
    t_store_ctl       mem_ctl;
    logic [AW-1:0]    mem_wr_addr;
    logic [7:0]       mem_wr_data;
    logic [AW-1:0]    mem_rd_addr;
    logic [7:0]       mem_rd_data;

    tcc_div #(
        .WW (WW),
        .CW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (cur_clamp),
        .i_divisor  (r_cols),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    tcc_store #(
        .DEPTH (STORE_CELLS),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        if (r_cols_in_use == 8'd0) begin
            cols_eff = CW'(1);
        end else if (32'(r_cols_in_use) > MAX_COLS) begin
            cols_eff = CW'(MAX_COLS);
        end else begin
            cols_eff = CW'(r_cols_in_use);
        end
        if (r_rows_in_use == 6'd0) begin
            rows_eff = RW'(1);
        end else if (32'(r_rows_in_use) > MAX_ROWS) begin
            rows_eff = RW'(MAX_ROWS);
        end else begin
            rows_eff = RW'(r_rows_in_use);
        end
        if (WW'(r_cursor) >= WW'(r_total)) begin
            cur_clamp = WW'(r_total) - WW'(1);
        end else begin
            cur_clamp = WW'(r_cursor);
        end
        line_start = r_cur - WW'(div_rem);
    end

    always_comb begin
        n_state       = r_state;
        n_cols_in_use = r_cols_in_use;
        n_rows_in_use = r_rows_in_use;
        n_cursor      = r_cursor;
        n_dst         = r_dst;
        n_mv          = r_mv;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_func        = r_func;
        n_char        = r_char;
        n_cols        = r_cols;
        n_rows        = r_rows;
        n_c           = r_c;
        n_r           = r_r;
        n_total       = r_total;
        n_lin         = r_lin;
        n_cur         = r_cur;
        n_src         = r_src;
        n_cell        = r_cell;
        n_out         = r_out;
        div_start     = 1'b0;
        mem_ctl       = '0;
        mem_wr_addr   = AW'(r_dst);
        mem_wr_data   = CH_SPACE;
        mem_rd_addr   = AW'(r_src);

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_COLS: n_cols_in_use = i_cfg_data[7:0];
                CFG_ROWS: n_rows_in_use = i_cfg_data[5:0];
                default: ;
            endcase
        end

        case (r_state)
            S_INIT: begin
                mem_ctl.wr_en = 1'b1;
                n_dst         = r_dst + TW'(1);
                if (r_dst == TW'(STORE_CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func = i_in_data.func;
                    n_char = i_in_data.char_code;
                    n_cols = cols_eff;
                    n_rows = rows_eff;
                    n_cell = 8'd0;
                    if (32'(i_in_data.col) + 1 > 32'(cols_eff)) begin
                        n_c = cols_eff - CW'(1);
                    end else begin
                        n_c = CW'(i_in_data.col);
                    end
                    if (32'(i_in_data.row) + 1 > 32'(rows_eff)) begin
                        n_r = rows_eff - RW'(1);
                    end else begin
                        n_r = RW'(i_in_data.row);
                    end
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_total = TW'(PW'(r_cols) * PW'(r_rows));
                n_lin   = TW'(PW'(r_r) * PW'(r_cols) + PW'(r_c));
                n_state = S_DISP;
            end
            S_DISP: begin
                case (r_func)
                    FN_PUT: begin
                        if (r_char inside {CH_NEWLINE, CH_RETURN}) begin
                            n_cur     = cur_clamp;
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end else begin
                            mem_ctl.wr_en = 1'b1;
                            mem_wr_addr   = AW'(cur_clamp);
                            mem_wr_data   = r_char;
                            n_cur         = cur_clamp + WW'(1);
                            n_state       = S_CHECK;
                        end
                    end
                    FN_SET: begin
                        n_cursor = CUR_W'(r_lin);
                        n_state  = S_DONE;
                    end
                    FN_CLEAR: begin
                        n_dst   = '0;
                        n_state = S_CLEAR;
                    end
                    default: begin
                        mem_ctl.rd_en = 1'b1;
                        mem_rd_addr   = AW'(r_lin);
                        n_state       = S_RDWAIT;
                    end
                endcase
            end
            S_RDWAIT: begin
                n_cell  = mem_rd_data;
                n_state = S_DONE;
            end
            S_DIV: begin
                if (div_done) begin
                    if (r_char == CH_NEWLINE) begin
                        n_cur = line_start + WW'(r_cols);
                    end else begin
                        n_cur = line_start;
                    end
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_cur >= WW'(r_total)) begin
                    n_cur   = r_cur - WW'(r_cols);
                    n_src   = TW'(r_cols);
                    n_dst   = '0;
                    n_mv    = 1'b0;
                    n_state = S_SCROLL;
                end else begin
                    n_cursor = CUR_W'(r_cur);
                    n_state  = S_DONE;
                end
            end
            S_SCROLL: begin
                // read one row ahead, write the cell read last cycle
                if (r_src < r_total) begin
                    mem_ctl.rd_en = 1'b1;
                    n_src         = r_src + TW'(1);
                    n_mv          = 1'b1;
                end else begin
                    n_mv = 1'b0;
                end
                if (r_mv) begin
                    mem_ctl.wr_en = 1'b1;
                    mem_wr_data   = mem_rd_data;
                    n_dst         = r_dst + TW'(1);
                end
                if (r_src >= r_total && !r_mv) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                mem_ctl.wr_en = 1'b1;
                n_dst         = r_dst + TW'(1);
                if (r_dst == r_total - TW'(1)) begin
                    n_cursor = CUR_W'(r_cur);
                    n_state  = S_DONE;
                end
            end
            S_CLEAR: begin
                mem_ctl.wr_en = 1'b1;
                n_dst         = r_dst + TW'(1);
                if (r_dst == r_total - TW'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.cursor_now = r_cursor;
                    n_out.cell_value = r_cell;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_INIT;
            r_cols_in_use <= COLS_RESET;
            r_rows_in_use <= ROWS_RESET;
            r_cursor      <= '0;
            r_dst         <= '0;
            r_mv          <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_cols_in_use <= n_cols_in_use;
            r_rows_in_use <= n_rows_in_use;
            r_cursor      <= n_cursor;
            r_dst         <= n_dst;
            r_mv          <= n_mv;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func  <= n_func;
        r_char  <= n_char;
        r_cols  <= n_cols;
        r_rows  <= n_rows;
        r_c     <= n_c;
        r_r     <= n_r;
        r_total <= n_total;
        r_lin   <= n_lin;
        r_cur   <= n_cur;
        r_src   <= n_src;
        r_cell  <= n_cell;
        r_out   <= n_out;
    end

    a_scroll_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCROLL && r_mv) |-> (r_dst < r_src))
        else $error("scroll write overtook read");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result beat raised outside completion");

    a_cursor_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_cursor) |-> ($past(r_state) == S_DISP || $past(r_state) == S_CHECK
                                || $past(r_state) == S_FILL))
        else $error("cursor moved in unexpected state");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished with nobody waiting");

endmodule
